[rtl/ulb_pkg.sv]
`timescale 1ns / 1ps

package ulb_pkg;

	// Block dimensions.
	localparam int NUM_LEDS    = 4;
	localparam int PERIOD_BITS = 16;
	localparam int LED_IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

	localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = {PERIOD_BITS{1'b1}};

	// Command characters.
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_ONE   = 8'h31;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// Request kinds on the input stream.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Depth of the queue between the parser and the LED engine.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	// Operation handed from the parser to the LED engine.
	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_TICK = 2'd1,
		OP_LOAD = 2'd2
	} op_kind_t;

	typedef struct packed {
		op_kind_t               kind;
		logic [LED_IDX_W-1:0]   led;
		logic [PERIOD_BITS-1:0] period;
	} op_t;

	// Reset period of LED i: 100 ms times its number.
	function automatic logic [PERIOD_BITS-1:0] reset_period(input int i);
		reset_period = PERIOD_BITS'(100 * (i + 1));
	endfunction

endpackage

[rtl/ulb_front.sv]
`timescale 1ns / 1ps

module ulb_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic           func,
	input  logic [7:0]     rx_byte,
	output ulb_pkg::op_t   op
);

	logic                            cmd_started_q;
	logic [7:0]                      sel_q;
	logic                            digits_done_q;
	logic [ulb_pkg::PERIOD_BITS-1:0] acc_q;

	logic [7:0]                      sel_idx;
	logic                            sel_valid;
	logic                            is_digit;
	logic [ulb_pkg::PERIOD_BITS+3:0] acc_next;

	// Selector decode and the next decimal accumulator value.
	always_comb begin
		sel_idx   = sel_q - ulb_pkg::CHAR_ONE;
		sel_valid = (sel_q >= ulb_pkg::CHAR_ONE) && (sel_idx < 8'(ulb_pkg::NUM_LEDS));
		is_digit  = (rx_byte >= ulb_pkg::CHAR_ZERO) && (rx_byte <= ulb_pkg::CHAR_NINE);
		acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ (ulb_pkg::PERIOD_BITS+4)'(rx_byte[3:0]);
	end

	// Classify the request into an operation for the LED engine.
	always_comb begin
		op.kind   = ulb_pkg::OP_NONE;
		op.led    = sel_idx[ulb_pkg::LED_IDX_W-1:0];
		op.period = acc_q;
		if (func == ulb_pkg::FUNC_TICK) begin
			op.kind = ulb_pkg::OP_TICK;
		end else if (cmd_started_q && rx_byte == ulb_pkg::CHAR_SPACE && sel_valid) begin
			op.kind = ulb_pkg::OP_LOAD;
		end
	end

	// Command parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_started_q <= 1'b0;
			sel_q         <= '0;
			digits_done_q <= 1'b0;
			acc_q         <= '0;
		end else if (push && func == ulb_pkg::FUNC_BYTE) begin
			priority if (!cmd_started_q) begin
				cmd_started_q <= 1'b1;
				sel_q         <= rx_byte;
				digits_done_q <= 1'b0;
				acc_q         <= '0;
			end else if (rx_byte == ulb_pkg::CHAR_SPACE) begin
				cmd_started_q <= 1'b0;
				sel_q         <= '0;
				digits_done_q <= 1'b0;
				acc_q         <= '0;
			end else if (!digits_done_q) begin
				if (is_digit) begin
					if (acc_next > (ulb_pkg::PERIOD_BITS+4)'(ulb_pkg::PERIOD_MAX)) begin
						acc_q <= ulb_pkg::PERIOD_MAX;
					end else begin
						acc_q <= acc_next[ulb_pkg::PERIOD_BITS-1:0];
					end
				end else begin
					digits_done_q <= 1'b1;
				end
			end
		end
	end

endmodule

[rtl/ulb_queue.sv]
`timescale 1ns / 1ps

module ulb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ulb_pkg::op_t  push_op,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output ulb_pkg::op_t  head_op
);

	ulb_pkg::op_t                entries_q [ulb_pkg::QDEPTH];
	logic [ulb_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [ulb_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [ulb_pkg::QCNT_W-1:0]  count_q;

	assign full    = (count_q == ulb_pkg::QCNT_W'(ulb_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign head_op = entries_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ulb_back.sv]
`timescale 1ns / 1ps

module ulb_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  ulb_pkg::op_t  q_op,
	output logic          q_pop,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [23:0]   m_tdata,
	output logic          m_tuser
);

	logic [ulb_pkg::PERIOD_BITS-1:0] period_q [ulb_pkg::NUM_LEDS];
	logic [ulb_pkg::PERIOD_BITS-1:0] phase_q  [ulb_pkg::NUM_LEDS];
	logic [ulb_pkg::NUM_LEDS-1:0]    level_q;

	logic [ulb_pkg::PERIOD_BITS-1:0] phase_d  [ulb_pkg::NUM_LEDS];
	logic [ulb_pkg::NUM_LEDS-1:0]    level_d;

	logic                            out_valid_q;
	logic [3:0]                      out_levels_q;
	logic                            out_upd_q;
	logic [1:0]                      out_led_q;
	logic [15:0]                     out_period_q;

	// Take the next operation whenever the output register is free or drains.
	assign q_pop = !q_empty && (!out_valid_q || m_tready);

	// Per-LED half-cycle counters for a tick.
	always_comb begin
		for (int i = 0; i < ulb_pkg::NUM_LEDS; i++) begin
			logic [ulb_pkg::PERIOD_BITS-1:0] p;
			logic [ulb_pkg::PERIOD_BITS:0]   n;
			p = (period_q[i] == '0) ? ulb_pkg::PERIOD_BITS'(1) : period_q[i];
			n = {1'b0, phase_q[i]} + 1'b1;
			if (n >= {1'b0, p}) begin
				phase_d[i] = '0;
				level_d[i] = ~level_q[i];
			end else begin
				phase_d[i] = n[ulb_pkg::PERIOD_BITS-1:0];
				level_d[i] = level_q[i];
			end
		end
	end

	// LED state: ticks advance the counters, loads replace one period.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ulb_pkg::NUM_LEDS; i++) begin
				period_q[i] <= ulb_pkg::reset_period(i);
				phase_q[i]  <= '0;
			end
			level_q <= '0;
		end else if (q_pop) begin
			unique case (q_op.kind)
				ulb_pkg::OP_TICK: begin
					phase_q <= phase_d;
					level_q <= level_d;
				end
				ulb_pkg::OP_LOAD: begin
					period_q[q_op.led] <= q_op.period;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_levels_q <= 4'((q_op.kind == ulb_pkg::OP_TICK) ? level_d : level_q);
			out_upd_q    <= (q_op.kind == ulb_pkg::OP_LOAD);
			out_led_q    <= (q_op.kind == ulb_pkg::OP_LOAD) ? 2'(q_op.led) : 2'd0;
			out_period_q <= (q_op.kind == ulb_pkg::OP_LOAD) ? 16'(q_op.period) : 16'd0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_period_q, out_led_q, out_levels_q};
	assign m_tuser  = out_upd_q;

	// A stalled result must not be overwritten.
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !q_pop)
		else $error("operation taken while result stalled");

	// Every operation taken produces a result.
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid_q)
		else $error("operation taken without result");

	// A load lands in the LED that it names.
	a_load_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_op.kind == ulb_pkg::OP_LOAD)
		|=> period_q[$past(q_op.led)] == $past(q_op.period))
		else $error("period load lost");

	// A load reports its period on the output.
	a_load_reported: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_op.kind == ulb_pkg::OP_LOAD)
		|=> (out_upd_q && out_period_q == 16'($past(q_op.period))))
		else $error("period load not reported");

endmodule

[rtl/uart_command_led_blinker.sv]
`timescale 1ns / 1ps
// UART command LED blinker.
// The input stream carries one request per item: s_tuser set means a one
// millisecond tick, s_tuser clear means a received UART byte in s_tdata.
// Commands are a selector byte '1' to '4', optional decimal digits and a
// space; they load that LED's half-cycle period (saturating at 65535).
// Every request yields exactly one result on the output stream: the four LED
// levels after the request, plus the loaded LED and period when the byte
// completed a valid command (m_tuser set).
// A request is registered in the queue and then in the output register before
// its result appears on the output.
// Throughput: one request per cycle while the receiver takes every result.
// A two-entry queue sits between parser and engine; when the receiver stalls
// the result holds in the output register, the queue fills, and s_tready
// drops once two further requests are waiting.
// Reset clears the parser, empties the queue and the output, sets all LEDs
// low with periods of 100, 200, 300 and 400 ms.
module uart_command_led_blinker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [3:0] led_levels, [5:4] updated_led,
	                               // [21:6] updated_period, [23:22] zero
	output logic        m_tuser    // [0] period_updated
);

	ulb_pkg::op_t front_op;
	ulb_pkg::op_t head_op;
	logic         push;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;

	assign s_tready = !q_full;
	assign push     = s_tvalid && s_tready;

	// Parser: classifies each request.
	ulb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.func    (s_tuser),
		.rx_byte (s_tdata),
		.op      (front_op)
	);

	// Queue between parser and LED engine.
	ulb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (front_op),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.head_op (head_op)
	);

	// LED engine and output register.
	ulb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_op     (head_op),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
